// ----- sv/arpc_pkg.sv -----
`default_nettype none

package arpc_pkg;

  localparam int ENTRIES_DEF = 8;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [IP_W-1:0]     ip_t;
  typedef logic [MAC_W-1:0]    mac_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_LEARN  = 1'b1;

  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_MISS     = 3'd1;
  localparam status_t ST_UPDATED  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_DROPPED  = 3'd4;

endpackage

`default_nettype wire

// ----- sv/arp_cache_table.sv -----
// Fully associative IPv4-to-MAC cache. busy stays low, so a request is taken
// on every cycle that start is high; each request returns one result on
// out_valid (held first in the input register, then passed through the
// parallel IP compare and lowest-index pick into the result
// register). Results cannot be stalled and must be taken when out_valid is
// high. Back-to-back requests see every table change made by the one before.
// Valid bits clear in the reset cycle itself; no clearing pass is needed.
// out_slot carries the low three bits of the entry index.
`default_nettype none

module arp_cache_table #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_opcode,
  input  wire arpc_pkg::ip_t     in_ip_addr,
  input  wire arpc_pkg::mac_t    in_mac_addr,
  output      logic              out_valid,
  output      arpc_pkg::status_t out_status,
  output      arpc_pkg::mac_t    out_mac_result,
  output      arpc_pkg::slot_t   out_slot
);
  import arpc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  logic               in_valid_r;
  logic               op_r;
  ip_t                ip_r;
  mac_t               mac_r;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  ip_t                entry_ip_r [ENTRIES];
  mac_t               entry_mac  [ENTRIES];

  logic [ENTRIES-1:0] match_vec;
  logic               match_any;
  idx_t               match_idx;
  logic               free_any;
  idx_t               free_idx;

  logic               wr_en;
  logic               wr_ip;
  idx_t               wr_idx;
  status_t            status_nxt;
  idx_t               slot_idx_nxt;
  logic               rd_hit;

  logic               out_valid_r;
  status_t            status_r;
  mac_t               mac_result_r;
  slot_t              slot_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    op_r  <= in_opcode;
    ip_r  <= in_ip_addr;
    mac_r <= in_mac_addr;
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (entry_ip_r[i] == ip_r);
    end
  end

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_ip        = 1'b0;
    wr_idx       = match_idx;
    rd_hit       = 1'b0;
    slot_idx_nxt = '0;
    valid_nxt    = valid_r;
    status_nxt   = ST_MISS;
    if (op_r == OP_LOOKUP) begin
      if (match_any) begin
        status_nxt   = ST_HIT;
        slot_idx_nxt = match_idx;
        rd_hit       = in_valid_r;
      end
    end else if (match_any) begin
      status_nxt   = ST_UPDATED;
      slot_idx_nxt = match_idx;
      wr_en        = in_valid_r;
    end else if (free_any) begin
      status_nxt   = ST_INSERTED;
      slot_idx_nxt = free_idx;
      wr_idx       = free_idx;
      wr_en        = in_valid_r;
      wr_ip        = in_valid_r;
      if (in_valid_r) begin
        valid_nxt[free_idx] = 1'b1;
      end
    end else begin
      status_nxt = ST_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= in_valid_r;
    end
    if (wr_ip) begin
      entry_ip_r[wr_idx] <= ip_r;
    end
    status_r <= status_nxt;
    slot_r   <= SLOT_W'(slot_idx_nxt);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mac[wr_idx] <= mac_r;
    end
    if (rd_hit) begin
      mac_result_r <= entry_mac[match_idx];
    end else begin
      mac_result_r <= '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_mac_result = mac_result_r;
  assign out_slot       = slot_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid)
    else $error("accepted request produced no result");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_HIT || out_status == ST_MISS ||
                   out_status == ST_UPDATED || out_status == ST_INSERTED ||
                   out_status == ST_DROPPED))
    else $error("illegal result status");

  a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_HIT) |-> (out_mac_result == '0))
    else $error("nonzero MAC on non-hit result");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS || out_status == ST_DROPPED))
      |-> (out_slot == '0))
    else $error("nonzero slot on miss or drop");

  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) >= $countones($past(valid_r))))
    else $error("valid entry lost");
`endif

endmodule

`default_nettype wire
